[hdl/mkpq_pkg.sv]
// Shared types and codes for the min-key priority queue.
package mkpq_pkg;

   // one stored entry: id tag and priority key
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] key;
   } entry_type;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_REMOVED  = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic accept;     // latch the request, prime the first read
      logic ins_shift;  // move the entry just read one slot toward the tail
      logic ins_put;    // write the new entry and close the insert
      logic pop_take;   // capture the front entry and drop it
      logic load_rsp;   // load the result register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic key_gt;      // entry read holds a strictly larger key
      logic last_shift;  // the entry read is the front entry
      logic rsp_free;    // result register can take a new result
   } dp_stat_type;

endpackage

[hdl/min_key_priority_queue.sv]
// One request is handled at a time; the next transfer is taken once the result is registered.
// An insert moves each entry with a larger key one slot toward the tail before the new entry is written.
// Remove is constant time: the store is a circular buffer and a pop only advances the head.
// Reset (synchronous, active high) empties the queue and drops any pending result;
// entry storage is not cleared, since only entries inside the occupied range are ever used.
module min_key_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [15:0] req_flight_id,
   input  logic [15:0] req_wait_minutes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_flight_id,
   output logic [15:0] rsp_out_wait_minutes,
   output logic [4:0]  rsp_occupancy
);

   // Command and status between the sequencer and the datapath.
   mkpq_pkg::ctl_cmd_type cmd;
   mkpq_pkg::dp_stat_type stat;

   // Sequencer: takes a transfer only when idle, walks an insert from the
   // tail toward the head one entry per cycle, and holds a finished result
   // until the result register is free.
   mkpq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // Datapath: the entry RAM with head, tail and count, the insert cursor,
   // the key compare, and the registered result that parts the two channels.
   mkpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_command          (req_command),
      .req_flight_id        (req_flight_id),
      .req_wait_minutes     (req_wait_minutes),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_out_flight_id    (rsp_out_flight_id),
      .rsp_out_wait_minutes (rsp_out_wait_minutes),
      .rsp_occupancy        (rsp_occupancy)
   );

endmodule

[hdl/mkpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mkpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/mkpq_ctrl.sv]
// Sequencer for the priority queue: accept, insert walk, pop, result hand-off.
module mkpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_command,
   output logic                  req_ready,
   input  mkpq_pkg::dp_stat_type stat,
   output mkpq_pkg::ctl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_PUT  = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_command == mkpq_pkg::CMD_INSERT) begin
                  if (stat.full) begin
                     state_in = S_FIN;
                  end else if (stat.empty) begin
                     state_in = S_PUT;
                  end else begin
                     state_in = S_INS;
                  end
               end else begin
                  state_in = stat.empty ? S_FIN : S_POP;
               end
            end
         end
         S_INS: begin
            if (stat.key_gt) begin
               cmd.ins_shift = 1'b1;
               if (stat.last_shift) begin
                  state_in = S_PUT;
               end
            end else begin
               cmd.ins_put = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_PUT: begin
            cmd.ins_put = 1'b1;
            state_in    = S_FIN;
         end
         S_POP: begin
            cmd.pop_take = 1'b1;
            state_in     = S_FIN;
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/mkpq_dp.sv]
// Datapath: circular entry store, head/tail/count, insert cursor, result register.
module mkpq_dp #(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mkpq_pkg::ctl_cmd_type cmd,
   output mkpq_pkg::dp_stat_type stat,
   input  logic                  req_command,
   input  logic [15:0]           req_flight_id,
   input  logic [15:0]           req_wait_minutes,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_out_flight_id,
   output logic [15:0]           rsp_out_wait_minutes,
   output logic [4:0]            rsp_occupancy
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

   logic [IW-1:0] head_ff, tail_ff, wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, j_ff;
   mkpq_pkg::entry_type new_ff, data_ff, rd_entry, wr_entry;
   logic [1:0] status_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [15:0]   rsp_id_ff, rsp_key_ff;
   logic [4:0]    rsp_occ_ff;

   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;

   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
      ptr_inc = (p == LAST_SLOT) ? '0 : p + IW'(1);
   endfunction

   function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
      ptr_dec = (p == '0) ? LAST_SLOT : p - IW'(1);
   endfunction

   // one write and one read per cycle: shift writes slot j while slot j-2 is read
   assign ram_we    = cmd.ins_shift | cmd.ins_put;
   assign ram_waddr = wr_ptr_ff;
   assign wr_entry  = cmd.ins_shift ? rd_entry : new_ff;
   assign ram_re    = cmd.accept | cmd.ins_shift;
   always_comb begin
      if (cmd.accept) begin
         ram_raddr = (req_command == mkpq_pkg::CMD_INSERT) ? ptr_dec(tail_ff) : head_ff;
      end else begin
         ram_raddr = ptr_dec(rd_ptr_ff);
      end
   end

   mkpq_ram #(
      .WIDTH ($bits(mkpq_pkg::entry_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_entry),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_entry)
   );

   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff == CW'(CAPACITY));
   assign stat.key_gt     = (rd_entry.key > new_ff.key);
   assign stat.last_shift = (j_ff == CW'(1));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_ff.id  <= req_flight_id;
         new_ff.key <= req_wait_minutes;
         data_ff    <= '0;
         wr_ptr_ff  <= tail_ff;
         rd_ptr_ff  <= ptr_dec(tail_ff);
         j_ff       <= count_ff;
         status_ff  <= (req_command == mkpq_pkg::CMD_INSERT) ?
                       mkpq_pkg::ST_FULL : mkpq_pkg::ST_EMPTY;
      end
      if (cmd.ins_shift) begin
         wr_ptr_ff <= rd_ptr_ff;
         rd_ptr_ff <= ptr_dec(rd_ptr_ff);
         j_ff      <= j_ff - CW'(1);
      end
      if (cmd.ins_put) begin
         status_ff <= mkpq_pkg::ST_INSERTED;
      end
      if (cmd.pop_take) begin
         data_ff   <= rd_entry;
         status_ff <= mkpq_pkg::ST_REMOVED;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_id_ff     <= data_ff.id;
         rsp_key_ff    <= data_ff.key;
         rsp_occ_ff    <= 5'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.ins_put) begin
            tail_ff  <= ptr_inc(tail_ff);
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.pop_take) begin
            head_ff  <= ptr_inc(head_ff);
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_flight_id    = rsp_id_ff;
   assign rsp_out_wait_minutes = rsp_key_ff;
   assign rsp_occupancy        = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_put_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_put |-> !stat.full)
      else $error("insert written into a full queue");

   a_take_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_take |-> !stat.empty)
      else $error("pop from an empty queue");

   a_shift_cursor: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_shift |-> j_ff != '0)
      else $error("insert shift past the front entry");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != mkpq_pkg::ST_REMOVED)
      |-> (rsp_id_ff == '0 && rsp_key_ff == '0))
      else $error("non-remove result carries entry data");

endmodule
